// ===== rtl/ptsched_pkg.sv =====
// Shared types and constants for the periodic timer scheduler.
// No dependencies; the other rtl files, except ptsched_ram, refer to this package by scoped names.
`timescale 1ns / 1ps
package ptsched_pkg;

  localparam int TIMER_SLOTS  = 16;
  localparam int SLOT_BITS    = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int TIME_BITS    = 32;
  localparam int PERIOD_BITS  = 16;
  localparam int SLOT_ID_BITS = 4;
  localparam int RAM_W        = PERIOD_BITS + TIME_BITS;
  localparam int QPTR_BITS    = 1;
  localparam int QUEUE_DEPTH  = 2 ** QPTR_BITS;

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_NO_SLOT = 2'd2;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_ADD,
    OP_REMOVE,
    OP_NONE
  } op_e;

  typedef struct packed {
    logic [1:0]             cmd;
    logic [PERIOD_BITS-1:0] period_ms;
    logic [3:0]             slot_sel;
  } req_t;

  typedef struct packed {
    logic [SLOT_ID_BITS-1:0] timer_slot;
    logic                    fired;
    logic [1:0]              status;
    logic                    last;
  } res_t;

  typedef struct packed {
    op_e                    op;
    logic [PERIOD_BITS-1:0] period;
    logic [3:0]             sel;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_chan_t;

  typedef struct packed {
    logic scan;
    logic done;
  } back_stat_t;

endpackage

// ===== rtl/ptsched_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
module ptsched_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ptsched_front.sv =====
// Front end: accepts command transactions, decodes them and queues them for the back end.
// Depends on ptsched_pkg.
`timescale 1ns / 1ps
module ptsched_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  ptsched_pkg::req_t     req_i,
  input  logic                  pop_i,
  output ptsched_pkg::job_chan_t job_o
);

  ptsched_pkg::job_t                  mem_q [ptsched_pkg::QUEUE_DEPTH];
  logic [ptsched_pkg::QPTR_BITS-1:0]  wr_ptr_q, wr_ptr_d;
  logic [ptsched_pkg::QPTR_BITS-1:0]  rd_ptr_q, rd_ptr_d;
  logic [ptsched_pkg::QPTR_BITS:0]    cnt_q, cnt_d;
  logic                               push;
  logic                               pop;
  ptsched_pkg::job_t                  job_in;

  always_comb begin
    job_in.period = req_i.period_ms;
    job_in.sel    = req_i.slot_sel;
    case (req_i.cmd)
      ptsched_pkg::CMD_TICK:   job_in.op = ptsched_pkg::OP_TICK;
      ptsched_pkg::CMD_ADD:    job_in.op = ptsched_pkg::OP_ADD;
      ptsched_pkg::CMD_REMOVE: job_in.op = ptsched_pkg::OP_REMOVE;
      default:                 job_in.op = ptsched_pkg::OP_NONE;
    endcase
  end

  assign busy = (cnt_q == (ptsched_pkg::QPTR_BITS + 1)'(ptsched_pkg::QUEUE_DEPTH));
  assign push = start && !busy;
  assign pop  = pop_i && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= job_in;
    end
  end

  assign job_o.valid = (cnt_q != '0);
  assign job_o.job   = mem_q[rd_ptr_q];

endmodule

// ===== rtl/ptsched_back.sv =====
// Back end: timer table, time count, slot scan on tick and the result register.
// Depends on ptsched_pkg and ptsched_ram.
`timescale 1ns / 1ps
module ptsched_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ptsched_pkg::job_chan_t job_i,
  output logic                   pop_o,
  output logic                   res_valid_o,
  output ptsched_pkg::res_t      res_o,
  output ptsched_pkg::back_stat_t stat_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam int SB = ptsched_pkg::SLOT_BITS;
  localparam int TB = ptsched_pkg::TIME_BITS;
  localparam int PB = ptsched_pkg::PERIOD_BITS;

  logic [1:0]                        state_q, state_d;
  logic [ptsched_pkg::TIMER_SLOTS-1:0] valid_q, valid_d;
  logic [TB-1:0]                     now_q, now_d;
  logic [SB:0]                       idx_q, idx_d;
  logic                              chk_v_q, chk_v_d;
  logic [SB-1:0]                     chk_idx_q, chk_idx_d;
  logic                              pend_v_q, pend_v_d;
  logic [SB-1:0]                     pend_slot_q, pend_slot_d;
  logic                              res_v_q, res_v_d;
  ptsched_pkg::res_t                 res_q, res_d;

  logic                              ram_we;
  logic [SB-1:0]                     ram_waddr;
  logic [ptsched_pkg::RAM_W-1:0]     ram_wdata;
  logic [SB-1:0]                     ram_raddr;
  logic [ptsched_pkg::RAM_W-1:0]     ram_rdata;
  logic [TB-1:0]                     rd_deadline;
  logic [PB-1:0]                     rd_period;

  logic                              free_found;
  logic [SB-1:0]                     free_idx;
  logic                              rm_hit;
  logic [ptsched_pkg::TIMER_SLOTS-1:0] rm_mask;
  logic                              fire;

  ptsched_ram #(
    .Width (ptsched_pkg::RAM_W),
    .Depth (ptsched_pkg::TIMER_SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_deadline = ram_rdata[TB-1:0];
  assign rd_period   = ram_rdata[ptsched_pkg::RAM_W-1:TB];

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = ptsched_pkg::TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = SB'(i);
      end
    end
  end

  always_comb begin
    rm_hit  = 1'b0;
    rm_mask = '0;
    for (int i = 0; i < ptsched_pkg::TIMER_SLOTS; i++) begin
      if (valid_q[i] && (32'(job_i.job.sel) == i)) begin
        rm_hit     = 1'b1;
        rm_mask[i] = 1'b1;
      end
    end
  end

  assign fire = chk_v_q && valid_q[chk_idx_q] && (rd_deadline == now_q);

  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    now_d       = now_q;
    idx_d       = idx_q;
    chk_v_d     = chk_v_q;
    chk_idx_d   = chk_idx_q;
    pend_v_d    = pend_v_q;
    pend_slot_d = pend_slot_q;
    res_v_d     = 1'b0;
    res_d       = res_q;
    pop_o       = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = chk_idx_q;
    ram_wdata   = {rd_period, rd_deadline + {{(TB - PB){1'b0}}, rd_period}};
    ram_raddr   = idx_q[SB-1:0];

    case (state_q)
      ST_IDLE: begin
        if (job_i.valid) begin
          pop_o = 1'b1;
          case (job_i.job.op)
            ptsched_pkg::OP_ADD: begin
              res_v_d = 1'b1;
              if (free_found) begin
                valid_d[free_idx] = 1'b1;
                ram_we    = 1'b1;
                ram_waddr = free_idx;
                ram_wdata = {job_i.job.period,
                             now_q + {{(TB - PB){1'b0}}, job_i.job.period}};
                res_d = '{timer_slot: ptsched_pkg::SLOT_ID_BITS'(free_idx), fired: 1'b0,
                          status: ptsched_pkg::STATUS_OK, last: 1'b1};
              end else begin
                res_d = '{timer_slot: '0, fired: 1'b0,
                          status: ptsched_pkg::STATUS_FULL, last: 1'b1};
              end
            end
            ptsched_pkg::OP_REMOVE: begin
              res_v_d = 1'b1;
              valid_d = valid_q & ~rm_mask;
              res_d = '{timer_slot: job_i.job.sel, fired: 1'b0,
                        status: rm_hit ? ptsched_pkg::STATUS_OK : ptsched_pkg::STATUS_NO_SLOT,
                        last: 1'b1};
            end
            ptsched_pkg::OP_TICK: begin
              now_d    = now_q + 1'b1;
              idx_d    = '0;
              chk_v_d  = 1'b0;
              pend_v_d = 1'b0;
              state_d  = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (idx_q < (SB + 1)'(ptsched_pkg::TIMER_SLOTS)) begin
          idx_d     = idx_q + 1'b1;
          chk_v_d   = 1'b1;
          chk_idx_d = idx_q[SB-1:0];
        end else begin
          chk_v_d = 1'b0;
        end
        if (fire) begin
          ram_we = 1'b1;
          if (pend_v_q) begin
            res_v_d = 1'b1;
            res_d = '{timer_slot: ptsched_pkg::SLOT_ID_BITS'(pend_slot_q), fired: 1'b1,
                      status: ptsched_pkg::STATUS_OK, last: 1'b0};
          end
          pend_v_d    = 1'b1;
          pend_slot_d = chk_idx_q;
        end
        if (chk_v_q && (chk_idx_q == SB'(ptsched_pkg::TIMER_SLOTS - 1))) begin
          chk_v_d = 1'b0;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        res_v_d = 1'b1;
        if (pend_v_q) begin
          res_d = '{timer_slot: ptsched_pkg::SLOT_ID_BITS'(pend_slot_q), fired: 1'b1,
                    status: ptsched_pkg::STATUS_OK, last: 1'b1};
        end else begin
          res_d = '{timer_slot: '0, fired: 1'b0,
                    status: ptsched_pkg::STATUS_OK, last: 1'b1};
        end
        pend_v_d = 1'b0;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      valid_q  <= '0;
      now_q    <= '0;
      idx_q    <= '0;
      chk_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
      res_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      now_q    <= now_d;
      idx_q    <= idx_d;
      chk_v_q  <= chk_v_d;
      pend_v_q <= pend_v_d;
      res_v_q  <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q   <= chk_idx_d;
    pend_slot_q <= pend_slot_d;
    res_q       <= res_d;
  end

  assign res_valid_o = res_v_q;
  assign res_o       = res_q;
  assign stat_o.scan = (state_q == ST_SCAN);
  assign stat_o.done = (state_q == ST_DONE);

endmodule

// ===== rtl/periodic_timer_scheduler_top.sv =====
// Top level of the periodic timer scheduler: front end queue plus back end timer table.
// Depends on ptsched_pkg, ptsched_front, ptsched_back and ptsched_ram.
//
// Usage:
//   Command channel: a transaction is taken on a rising edge with start high and busy low.
//   req_i.cmd selects tick, add or remove; period_ms is used by add, slot_sel by remove.
//   Commands wait in a two-entry queue; busy is high while that queue is full.
//   Result channel: every report sits on res_o for one cycle with res_valid_o high.
//   The receiver cannot stall; reports are never held back or repeated.
//   Add and remove: one report, registered in the cycle after the back end takes the command.
//   Tick: a scan of all 16 slots through the timer table RAM, one slot read per cycle;
//   one report per expired slot in ascending order, last marked, or a single no-expiry report.
//   Sustained rate: one add or remove per cycle while no tick scan runs; a tick holds off all commands.
//   Unused command code: taken and dropped, no report.
//   Reset: clears the time count, all slot valid bits and the queue; the table RAM
//   is not cleared, entries are written by add before use.
`timescale 1ns / 1ps
module periodic_timer_scheduler_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ptsched_pkg::req_t req_i,
  output logic              res_valid_o,
  output ptsched_pkg::res_t res_o
);

  ptsched_pkg::job_chan_t  job;
  logic                    pop;
  ptsched_pkg::back_stat_t stat;

  ptsched_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .pop_i  (pop),
    .job_o  (job)
  );

  ptsched_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job),
    .pop_o       (pop),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .stat_o      (stat)
  );

  a_pop_needs_job : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> job.valid && !stat.scan && !stat.done)
    else $error("back end took a transaction from an empty queue or while scanning");

  a_fire_from_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.fired |-> $past(stat.scan || stat.done))
    else $error("expiry report outside a tick scan");

  a_scan_ends_once : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.done |=> res_valid_o && res_o.last && !stat.scan && !stat.done)
    else $error("tick scan ended without a final report");

  a_single_report_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.fired |-> res_o.last &&
      (res_o.status == ptsched_pkg::STATUS_OK || res_o.status == ptsched_pkg::STATUS_FULL ||
       res_o.status == ptsched_pkg::STATUS_NO_SLOT))
    else $error("non-expiry report not marked last");

endmodule

// ===== sim/ptsched_report_checker.sv =====
`timescale 1ns / 1ps
// Report checker for the periodic timer scheduler: keeps its own timer table,
// predicts the reports of every accepted transaction and compares them in order.
// Depends on ptsched_pkg.
module ptsched_report_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  ptsched_pkg::req_t req_i,
  input  logic              res_valid_i,
  input  ptsched_pkg::res_t res_i,
  output int                mismatches_o,
  output int                outstanding_o
);
  import ptsched_pkg::*;

  logic                   armed        [TIMER_SLOTS];
  logic [PERIOD_BITS-1:0] period_tbl   [TIMER_SLOTS];
  logic [TIME_BITS-1:0]   deadline_tbl [TIMER_SLOTS];
  logic [TIME_BITS-1:0]   now_ms;
  res_t                   pending_reports [$];
  int                     mismatches;

  task automatic schedule_command(input req_t cmd_req);
    res_t report;
    int   free_slot;
    int   fired_count;
    free_slot   = -1;
    fired_count = 0;
    report      = '0;
    case (op_e'(cmd_req.cmd))
      OP_ADD: begin
        for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
          if (!armed[i]) free_slot = i;
        end
        if (free_slot < 0) begin
          report.status = STATUS_FULL;
        end else begin
          armed[free_slot]        = 1'b1;
          period_tbl[free_slot]   = cmd_req.period_ms;
          deadline_tbl[free_slot] = now_ms + TIME_BITS'(cmd_req.period_ms);
          report.timer_slot       = SLOT_ID_BITS'(free_slot);
          report.status           = STATUS_OK;
        end
        report.last = 1'b1;
        pending_reports.push_back(report);
      end
      OP_REMOVE: begin
        report.timer_slot      = cmd_req.slot_sel;
        report.status          = armed[cmd_req.slot_sel] ? STATUS_OK : STATUS_NO_SLOT;
        report.last            = 1'b1;
        armed[cmd_req.slot_sel] = 1'b0;
        pending_reports.push_back(report);
      end
      OP_TICK: begin
        now_ms = now_ms + 1'b1;
        for (int i = 0; i < TIMER_SLOTS; i++) begin
          if (armed[i] && deadline_tbl[i] == now_ms) begin
            deadline_tbl[i]   = deadline_tbl[i] + TIME_BITS'(period_tbl[i]);
            report.timer_slot = SLOT_ID_BITS'(i);
            report.fired      = 1'b1;
            report.status     = STATUS_OK;
            report.last       = 1'b0;
            pending_reports.push_back(report);
            fired_count++;
          end
        end
        if (fired_count == 0) begin
          report.status = STATUS_OK;
          report.last   = 1'b1;
          pending_reports.push_back(report);
        end else begin
          report      = pending_reports.pop_back();
          report.last = 1'b1;
          pending_reports.push_back(report);
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_report(input res_t got);
    res_t want;
    if (pending_reports.size() == 0) begin
      $error("unexpected report: timer_slot=%0d fired=%0b status=%0d last=%0b",
             got.timer_slot, got.fired, got.status, got.last);
      mismatches++;
    end else begin
      want = pending_reports.pop_front();
      if (got.timer_slot !== want.timer_slot) begin
        $error("timer_slot: expected %0d, got %0d", want.timer_slot, got.timer_slot);
        mismatches++;
      end
      if (got.fired !== want.fired) begin
        $error("fired: expected %0b, got %0b", want.fired, got.fired);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TIMER_SLOTS; i++) begin
        armed[i] = 1'b0;
      end
      now_ms = '0;
      pending_reports.delete();
      mismatches    = 0;
      mismatches_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (start_i && !busy_i) schedule_command(req_i);
      if (res_valid_i) check_report(res_i);
      mismatches_o  <= mismatches;
      outstanding_o <= pending_reports.size();
    end
  end

endmodule

// ===== sim/periodic_timer_scheduler_top_test.sv =====
`timescale 1ns / 1ps
// Testbench top for the periodic timer scheduler: clock, reset and command stimulus.
// Depends on ptsched_pkg, periodic_timer_scheduler_top and ptsched_report_checker.
module periodic_timer_scheduler_top_test;
  import ptsched_pkg::*;

  localparam int RANDOM_ITEMS = 235;
  localparam int CALM_TAIL    = 40;
  localparam int CYCLE_LIMIT  = 200000;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req;
  logic res_valid;
  res_t res;
  int   mismatches;
  int   outstanding;
  int   cycle_count;

  periodic_timer_scheduler_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ptsched_report_checker report_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .req_i         (req),
    .res_valid_i   (res_valid),
    .res_i         (res),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  task automatic issue_command(input logic [1:0] cmd, input logic [PERIOD_BITS-1:0] period,
                               input logic [3:0] sel);
    start <= 1'b1;
    req   <= req_t'{cmd: cmd, period_ms: period, slot_sel: sel};
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain_reports();
    start <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  function automatic logic [PERIOD_BITS-1:0] pick_period();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return PERIOD_BITS'($urandom_range(1, 8));
    if (roll < 90) return PERIOD_BITS'($urandom_range(1, 40));
    return PERIOD_BITS'($urandom_range(0, 65535));
  endfunction

  initial begin
    logic [PERIOD_BITS-1:0] add_periods [16];
    logic [1:0] cmd;
    int         roll;
    int         counted;
    bit         midway_drained;
    add_periods = '{1, 2, 16'hFFFF, 0, 1, 3, 1, 2,
                    5, 1, 4, 2, 1, 7, 3, 1};
    rst_ni = 1'b0;
    start  = 1'b0;
    req    = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue_command(CMD_TICK, 16'hFFFF, 4'hF);
    issue_command(CMD_REMOVE, 16'h0000, 4'h0);
    issue_command(CMD_REMOVE, 16'hFFFF, 4'hF);
    issue_command(OP_NONE, 16'hFFFF, 4'hF);
    foreach (add_periods[i]) issue_command(CMD_ADD, add_periods[i], 4'(i));
    issue_command(CMD_ADD, 16'h5555, 4'hA);
    issue_command(CMD_TICK, 16'h0000, 4'h0);
    issue_command(CMD_REMOVE, 16'h0000, 4'h6);
    issue_command(CMD_ADD, 16'h0001, 4'h0);
    issue_command(CMD_TICK, 16'h0000, 4'h0);
    drain_reports();

    counted        = 0;
    midway_drained = 1'b0;
    while (counted < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 50) cmd = CMD_TICK;
      else if (roll < 75) cmd = CMD_ADD;
      else if (roll < 95) cmd = CMD_REMOVE;
      else cmd = OP_NONE;
      issue_command(cmd, pick_period(), 4'($urandom_range(0, 15)));
      if (cmd != OP_NONE) counted++;
      if (!midway_drained && counted >= RANDOM_ITEMS / 2) begin
        midway_drained = 1'b1;
        drain_reports();
      end else if (counted < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 2) == 0) begin
        pause_sender($urandom_range(1, 14));
      end
    end

    drain_reports();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ptsched_pkg.sv
rtl/ptsched_ram.sv
rtl/ptsched_front.sv
rtl/ptsched_back.sv
rtl/periodic_timer_scheduler_top.sv
sim/ptsched_report_checker.sv
sim/periodic_timer_scheduler_top_test.sv
